// File: rtl/cpd_pkg.sv
package cpd_pkg;

  // Default largest payload length of a variable frame.
  localparam int unsigned MaxPayloadDef = 256;

  // Header bytes ahead of the header CRC byte.
  localparam int unsigned HdrDataLen = 4;

  // CRC-8 generator polynomial, no reflection, no final inversion.
  localparam logic [7:0] CrcPoly = 8'h07;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CRC  = 2'd1;
  localparam logic [1:0] ERR_SIZE = 2'd2;
  localparam logic [1:0] ERR_LINE = 2'd3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [6:0]  frame_tag;
    logic [7:0]  command;
    logic        variable_frame;
    logic [15:0] fixed_value;
    logic [8:0]  payload_len;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [1:0]  fault_code;
  } res_t;

  // One byte step of the CRC, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/cpd_parser.sv
module cpd_parser import cpd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  input  logic       line_error_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);

  localparam logic PH_HEADER  = 1'b0;
  localparam logic PH_PAYLOAD = 1'b1;

  logic            phase_q, phase_d;
  logic [2:0]      hdr_cnt_q, hdr_cnt_d;
  logic [7:0]      hdr_q [HdrDataLen];
  logic            hdr_we;
  logic [7:0]      crc_q, crc_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;

  logic [15:0] value;
  logic [15:0] len_ext;
  logic [15:0] cnt_ext;
  logic        crc_good;

  assign value    = {hdr_q[3], hdr_q[2]};
  assign len_ext  = 16'(len_q);
  assign cnt_ext  = 16'(cnt_q);
  assign crc_good = (crc_q == rx_byte_i);

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    crc_d       = crc_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    hdr_we      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (take_i) begin
      if (line_error_i) begin
        phase_d           = PH_HEADER;
        hdr_cnt_d         = '0;
        crc_d             = '0;
        len_d             = '0;
        cnt_d             = '0;
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_REJECT;
        res_o.fault_code  = ERR_LINE;
      end else if (phase_q == PH_HEADER) begin
        if (hdr_cnt_q < 3'(HdrDataLen)) begin
          hdr_we    = 1'b1;
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          crc_d     = crc8_step(crc_q, rx_byte_i);
        end else begin
          // Header CRC byte: by default the frame ends here.
          phase_d              = PH_HEADER;
          hdr_cnt_d            = '0;
          crc_d                = '0;
          len_d                = '0;
          cnt_d                = '0;
          res_o.frame_tag      = hdr_q[0][6:0];
          res_o.command        = hdr_q[1];
          res_o.variable_frame = hdr_q[0][7];
          if (!hdr_q[0][7]) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = crc_good ? KIND_ACCEPT : KIND_REJECT;
            res_o.fault_code  = crc_good ? ERR_NONE : ERR_CRC;
            res_o.fixed_value = crc_good ? value : 16'd0;
          end else if (!crc_good) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = KIND_REJECT;
            res_o.fault_code  = ERR_CRC;
          end else if (value > 16'(MAX_PAYLOAD)) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = KIND_REJECT;
            res_o.fault_code  = ERR_SIZE;
          end else begin
            phase_d = PH_PAYLOAD;
            len_d   = value[LenW-1:0];
          end
        end
      end else begin
        res_valid_o          = 1'b1;
        res_o.frame_tag      = hdr_q[0][6:0];
        res_o.command        = hdr_q[1];
        res_o.variable_frame = 1'b1;
        res_o.payload_len    = len_ext[8:0];
        if (cnt_q < len_q) begin
          res_o.result_kind  = KIND_BYTE;
          res_o.fault_code   = ERR_NONE;
          res_o.payload_byte = rx_byte_i;
          res_o.byte_index   = cnt_ext[7:0];
          crc_d              = crc8_step(crc_q, rx_byte_i);
          cnt_d              = cnt_q + LenW'(1);
        end else begin
          // Payload CRC byte closes the frame.
          res_o.result_kind = crc_good ? KIND_ACCEPT : KIND_REJECT;
          res_o.fault_code  = crc_good ? ERR_NONE : ERR_CRC;
          phase_d           = PH_HEADER;
          hdr_cnt_d         = '0;
          crc_d             = '0;
          len_d             = '0;
          cnt_d             = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= '0;
      crc_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      crc_q     <= crc_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
    end
  end

  // Header bytes are always written before they are read within a frame.
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_cnt_q[1:0]] <= rx_byte_i;
    end
  end

endmodule

// File: rtl/cpd_out_buf.sv
module cpd_out_buf import cpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic space_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q;
  res_t skid_q;
  logic pop;
  logic load_main;
  logic load_skid;
  logic main_from_skid;

  assign pop         = main_valid_q & out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign res_o       = main_q;

  always_comb begin
    main_valid_d   = main_valid_q;
    skid_valid_d   = skid_valid_q;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    main_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        main_from_skid = 1'b1;
        skid_valid_d   = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        load_main    = 1'b1;
        main_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_from_skid) begin
      main_q <= skid_q;
    end else if (load_main) begin
      main_q <= res_i;
    end
    if (load_skid) begin
      skid_q <= res_i;
    end
  end

endmodule

// File: rtl/crc8_packet_deframer.sv
// Byte-stream frame parser with CRC-8 checks.
// Received bytes enter one word per handshake on the input channel
// (in_valid_i/in_ready_o, with rx_byte_i and line_error_i). Each frame has a
// five-byte header: flag and id, command, a little-endian 16-bit value and a
// CRC-8 over the first four bytes. Variable frames then carry the announced
// number of payload bytes and a payload CRC-8.
// The output channel (out_valid_o/out_ready_i) carries one result word per
// payload byte and one accept or reject word per frame; header bytes and the
// header CRC of a good variable frame give no word. A line error restarts the
// parser and gives a reject word at once.
// A result is registered in the output buffer and presented from there.
// Throughput is one input word per cycle while the output buffer has room,
// set by the single CRC byte step and counter update done between the parser
// state and the result register. A two-word output buffer keeps input flowing
// while one result waits; in_ready_o falls only when both entries are held by
// a stalled receiver. Reset clears the parser to the start of a header and
// empties the output buffer.
module crc8_packet_deframer import cpd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        line_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [6:0]  frame_tag_o,
  output logic [7:0]  command_o,
  output logic        variable_frame_o,
  output logic [15:0] fixed_value_o,
  output logic [8:0]  payload_len_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  byte_index_o,
  output logic [1:0]  fault_code_o
);

  logic take;
  logic res_valid;
  res_t res;
  res_t res_out;

  // A word is taken whenever the buffer has room for a possible result.
  assign take = in_valid_i & in_ready_o;

  cpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (rx_byte_i),
    .line_error_i(line_error_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cpd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .res_i      (res),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign result_kind_o    = res_out.result_kind;
  assign frame_tag_o      = res_out.frame_tag;
  assign command_o        = res_out.command;
  assign variable_frame_o = res_out.variable_frame;
  assign fixed_value_o    = res_out.fixed_value;
  assign payload_len_o    = res_out.payload_len;
  assign payload_byte_o   = res_out.payload_byte;
  assign byte_index_o     = res_out.byte_index;
  assign fault_code_o     = res_out.fault_code;

endmodule

// File: tb/crc8_packet_deframer_tb.sv
// Self-checking testbench for the CRC-8 packet deframer.
//
// Received bytes go in one word per handshake on the input channel. Every
// word that the block takes is fed at once to a behavioural deframer kept in
// this file, and any result word that the deframer predicts is queued. The
// output monitor pops the oldest queued word for each result word that it
// takes and compares it field by field. A result word with nothing queued, a
// wrong field, or a queued word still waiting at the end counts as a failure.
//
// Stimulus comes in two parts. A short directed table covers the extreme
// header values, the line error, the bad header CRC, the oversized length and
// the empty variable frame. Its header and payload CRC bytes are worked out
// from the deframer state when the row is driven. Then come four random
// phases with different idling on the two channels. Most random frames are
// well formed with random content, so that the payload path is reached
// often. The rest carry corrupted CRCs, are cut short by a line error, or are
// short bursts of noise that a line error then clears.
module crc8_packet_deframer_tb;
  import cpd_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned PhaseWords = 500;
  localparam int unsigned MaxReports = 10;

  // Where a directed row takes its byte from. The CRC sources are resolved
  // against the deframer state at the moment the row is driven.
  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_HDR_GOOD,
    SRC_HDR_BAD,
    SRC_PAY_GOOD,
    SRC_PAY_BAD
  } byte_src_e;

  typedef struct {
    byte_src_e  src;
    logic [7:0] data;
    logic       lerr;
    bit         typed;
    res_t       want;
  } dir_row_t;

  typedef enum logic {HUNT_HEADER, TAKE_PAYLOAD} deframe_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        line_error_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [6:0]  frame_tag_o;
  logic [7:0]  command_o;
  logic        variable_frame_o;
  logic [15:0] fixed_value_o;
  logic [8:0]  payload_len_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  byte_index_o;
  logic [1:0]  fault_code_o;

  crc8_packet_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .line_error_i     (line_error_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .frame_tag_o      (frame_tag_o),
    .command_o        (command_o),
    .variable_frame_o (variable_frame_o),
    .fixed_value_o    (fixed_value_o),
    .payload_len_o    (payload_len_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .fault_code_o     (fault_code_o)
  );

  always #5 clk_i = ~clk_i;

  // Behavioural deframer state. The header buffer starts at zero and, like the
  // block's, keeps its contents across a restart; the block's has no reset.
  deframe_phase_e df_phase    = HUNT_HEADER;
  int unsigned    hdr_seen    = 0;
  logic [7:0]     hdr_buf [4] = '{default: 8'h00};
  logic [7:0]     pay_crc     = 8'h00;
  logic [8:0]     pay_len     = 9'd0;
  logic [8:0]     pay_seen    = 9'd0;

  res_t        frame_results_due [$];
  dir_row_t    dir_tab [$];
  res_t        seen_res;
  res_t        due_res;
  int unsigned words_sent = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // CRC-8, polynomial x^8 + x^2 + x + 1, fed one data bit at a time, MSB
  // first, with the feedback taken from the top of the register.
  function automatic logic [7:0] crc8_fold_byte(input logic [7:0] crc,
                                                input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] header_crc();
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 4; i++) begin
      c = crc8_fold_byte(c, hdr_buf[2'(i)]);
    end
    return c;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [6:0] id,
                                  input logic [7:0] cmd, input logic var_frm,
                                  input logic [15:0] fixed, input logic [8:0] size,
                                  input logic [7:0] pbyte, input logic [7:0] idx,
                                  input logic [1:0] err);
    return {kind, id, cmd, var_frm, fixed, size, pbyte, idx, err};
  endfunction

  function automatic void restart_deframer();
    df_phase = HUNT_HEADER;
    hdr_seen = 0;
    pay_crc  = 8'h00;
    pay_len  = 9'd0;
    pay_seen = 9'd0;
  endfunction

  // Advances the deframer by one received word and gives the result word it
  // causes, if any. The id and command are read from the header buffer
  // before this word can change it.
  function automatic void deframe_word(input logic [7:0] b, input logic lerr,
                                       output bit has, output res_t r);
    logic [6:0]  id;
    logic [7:0]  cmd;
    logic [7:0]  c;
    logic [15:0] val;
    logic [8:0]  len;
    has = 1'b1;
    r   = '0;
    id  = hdr_buf[0][6:0];
    cmd = hdr_buf[1];
    if (lerr) begin
      restart_deframer();
      r = mk_res(KIND_REJECT, 7'd0, 8'd0, 1'b0, 16'd0, 9'd0, 8'd0, 8'd0, ERR_LINE);
      return;
    end
    if (df_phase == HUNT_HEADER) begin
      if (hdr_seen < 4) begin
        hdr_buf[hdr_seen[1:0]] = b;
        hdr_seen++;
        has = 1'b0;
        return;
      end
      c   = header_crc();
      val = {hdr_buf[3], hdr_buf[2]};
      if (!hdr_buf[0][7]) begin
        // Fixed frame: the header value is the whole payload.
        restart_deframer();
        if (c != b) begin
          r = mk_res(KIND_REJECT, id, cmd, 1'b0, 16'd0, 9'd0, 8'd0, 8'd0, ERR_CRC);
        end else begin
          r = mk_res(KIND_ACCEPT, id, cmd, 1'b0, val, 9'd0, 8'd0, 8'd0, ERR_NONE);
        end
      end else if (c != b) begin
        restart_deframer();
        r = mk_res(KIND_REJECT, id, cmd, 1'b1, 16'd0, 9'd0, 8'd0, 8'd0, ERR_CRC);
      end else if (val > MaxPayloadDef) begin
        restart_deframer();
        r = mk_res(KIND_REJECT, id, cmd, 1'b1, 16'd0, 9'd0, 8'd0, 8'd0, ERR_SIZE);
      end else begin
        df_phase = TAKE_PAYLOAD;
        hdr_seen = 0;
        pay_len  = val[8:0];
        pay_seen = 9'd0;
        pay_crc  = 8'h00;
        has      = 1'b0;
      end
      return;
    end
    if (pay_seen < pay_len) begin
      r = mk_res(KIND_BYTE, id, cmd, 1'b1, 16'd0, pay_len, b, pay_seen[7:0], ERR_NONE);
      pay_crc = crc8_fold_byte(pay_crc, b);
      pay_seen++;
      return;
    end
    // Payload CRC byte closes the variable frame.
    len = pay_len;
    c   = pay_crc;
    restart_deframer();
    if (c != b) begin
      r = mk_res(KIND_REJECT, id, cmd, 1'b1, 16'd0, len, 8'd0, 8'd0, ERR_CRC);
    end else begin
      r = mk_res(KIND_ACCEPT, id, cmd, 1'b1, 16'd0, len, 8'd0, 8'd0, ERR_NONE);
    end
  endfunction

  // Offers one word to the block and waits until it is taken. Idle cycles are
  // only ever inserted before valid rises, so valid never drops while a word
  // is pending. Once the word has been taken, the deframer is advanced and a
  // typed expectation, where the row has one, replaces the predicted word.
  task automatic send_word(input logic [7:0] b, input logic lerr,
                           input bit typed, input res_t want);
    bit   has;
    res_t r;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    line_error_i <= lerr;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    deframe_word(b, lerr, has, r);
    if (has) begin
      frame_results_due.push_back(typed ? want : r);
    end
    words_sent++;
  endtask

  function automatic void add_row(input byte_src_e src, input logic [7:0] data,
                                  input logic lerr, input bit typed, input res_t want);
    dir_row_t row;
    row.src   = src;
    row.data  = data;
    row.lerr  = lerr;
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endfunction

  // Builds one random frame and sends it. Lengths are mostly short, with the
  // odd frame near or at the largest payload so that every byte index is
  // reached. A frame may be cut short by a line error, and a noise burst is
  // always closed by one so that the next frame starts on a header.
  task automatic random_frame();
    logic [7:0]  fb [$];
    logic [15:0] val;
    logic [7:0]  b0;
    logic [7:0]  c;
    logic [7:0]  pb;
    int unsigned sel;
    int unsigned pick;
    int unsigned len;
    int          cut;
    bit          hdr_ok;
    sel = $urandom_range(0, 99);
    cut = -1;
    if (sel < 10) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        fb.push_back(8'($urandom));
      end
      fb.push_back(8'($urandom));
      cut = fb.size() - 1;
    end else begin
      b0  = 8'($urandom);
      val = 16'($urandom);
      if (sel < 40) begin
        b0[7] = 1'b0;
      end else begin
        b0[7] = 1'b1;
        pick  = $urandom_range(0, 99);
        if (pick < 4) begin
          val = $urandom_range(0, 1) ? 16'(MaxPayloadDef) : 16'($urandom_range(150, 256));
        end else if (pick < 9) begin
          val = $urandom_range(0, 1) ? 16'(MaxPayloadDef + 1) : 16'($urandom_range(257, 65535));
        end else begin
          val = 16'($urandom_range(0, 10));
        end
      end
      fb.push_back(b0);
      fb.push_back(8'($urandom));
      fb.push_back(val[7:0]);
      fb.push_back(val[15:8]);
      c = 8'h00;
      foreach (fb[k]) begin
        c = crc8_fold_byte(c, fb[k]);
      end
      hdr_ok = ($urandom_range(0, 99) < 88);
      fb.push_back(hdr_ok ? c : c ^ (8'h01 << $urandom_range(0, 7)));
      if (b0[7] && hdr_ok && val <= MaxPayloadDef) begin
        c = 8'h00;
        for (int i = 0; i < val; i++) begin
          pb = 8'($urandom);
          fb.push_back(pb);
          c = crc8_fold_byte(c, pb);
        end
        fb.push_back(($urandom_range(0, 99) < 85) ? c : c ^ (8'h01 << $urandom_range(0, 7)));
      end
      if ($urandom_range(0, 99) < 5) begin
        cut = $urandom_range(0, fb.size() - 1);
      end
    end
    foreach (fb[i]) begin
      send_word(fb[i], i == cut, 1'b0, '0);
      if (i == cut) begin
        break;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    fail_cnt++;
    if (fail_cnt <= MaxReports) begin
      $display("%0s at cycle %0d (expected/actual): kind %0d/%0d id %0h/%0h cmd %0h/%0h",
               what, cycle_cnt, want.result_kind, got.result_kind, want.frame_tag,
               got.frame_tag, want.command, got.command);
      $display("  var %0d/%0d fixed %0h/%0h size %0d/%0d byte %0h/%0h idx %0d/%0d err %0d/%0d",
               want.variable_frame, got.variable_frame, want.fixed_value, got.fixed_value,
               want.payload_len, got.payload_len, want.payload_byte, got.payload_byte,
               want.byte_index, got.byte_index, want.fault_code, got.fault_code);
    end
  endtask

  // Receiver: ready is redrawn at every edge according to the stall rate of
  // the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Output monitor. Outputs are sampled at the edge, before any update that
  // the edge causes, so the word seen is the one that the handshake moves.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = {result_kind_o, frame_tag_o, command_o, variable_frame_o, fixed_value_o,
                  payload_len_o, payload_byte_o, byte_index_o, fault_code_o};
      if (frame_results_due.size() == 0) begin
        report_mismatch("unexpected result word", '0, seen_res);
      end else begin
        due_res = frame_results_due.pop_front();
        if (seen_res !== due_res) begin
          report_mismatch("result word mismatch", due_res, seen_res);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d result words outstanding", cycle_cnt,
               frame_results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0]  b;
    int unsigned stop_at;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    rx_byte_i    <= 8'h00;
    line_error_i <= 1'b0;

    // Directed table. Rows with a typed result can be checked by eye; the
    // header bytes in between are left to the deframer, which predicts none.
    // A line error straight after reset gives an all-zero reject.
    add_row(SRC_LIT, 8'h00, 1'b1, 1'b1,
            mk_res(KIND_REJECT, 7'h00, 8'h00, 1'b0, 16'h0000, 9'd0, 8'h00, 8'h00, ERR_LINE));
    // Fixed frame with every header field at its top value.
    add_row(SRC_LIT, 8'h7F, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'hFF, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'hFF, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'hFF, 1'b0, 1'b0, '0);
    add_row(SRC_HDR_GOOD, 8'h00, 1'b0, 1'b1,
            mk_res(KIND_ACCEPT, 7'h7F, 8'hFF, 1'b0, 16'hFFFF, 9'd0, 8'h00, 8'h00, ERR_NONE));
    // All-zero fixed header: its CRC is zero, so a CRC byte of one is bad.
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h01, 1'b0, 1'b1,
            mk_res(KIND_REJECT, 7'h00, 8'h00, 1'b0, 16'h0000, 9'd0, 8'h00, 8'h00, ERR_CRC));
    // Variable frame announcing one byte more than the largest payload.
    add_row(SRC_LIT, 8'hFF, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h01, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h01, 1'b0, 1'b0, '0);
    add_row(SRC_HDR_GOOD, 8'h00, 1'b0, 1'b1,
            mk_res(KIND_REJECT, 7'h7F, 8'h00, 1'b1, 16'h0000, 9'd0, 8'h00, 8'h00, ERR_SIZE));
    // Variable frame whose header CRC is wrong.
    add_row(SRC_LIT, 8'h80, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h55, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h01, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_HDR_BAD, 8'h00, 1'b0, 1'b1,
            mk_res(KIND_REJECT, 7'h00, 8'h55, 1'b1, 16'h0000, 9'd0, 8'h00, 8'h00, ERR_CRC));
    // Empty variable frame: the payload CRC byte follows the header at once.
    add_row(SRC_LIT, 8'h80, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'hAA, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_LIT, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_HDR_GOOD, 8'h00, 1'b0, 1'b0, '0);
    add_row(SRC_PAY_GOOD, 8'h00, 1'b0, 1'b1,
            mk_res(KIND_ACCEPT, 7'h00, 8'hAA, 1'b1, 16'h0000, 9'd0, 8'h00, 8'h00, ERR_NONE));

    restart_deframer();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      case (dir_tab[i].src)
        SRC_HDR_GOOD: b = header_crc();
        SRC_HDR_BAD:  b = header_crc() ^ 8'h01;
        SRC_PAY_GOOD: b = pay_crc;
        SRC_PAY_BAD:  b = pay_crc ^ 8'h01;
        default:      b = dir_tab[i].data;
      endcase
      send_word(b, dir_tab[i].lerr, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases: free flow, an idle sender, a stalling receiver, and both
    // at a lighter rate.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      stop_at = words_sent + PhaseWords;
      while (words_sent < stop_at) begin
        random_frame();
      end
    end

    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (frame_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    // Keep the clock running so that a stray late result word would still be seen.
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cpd_pkg.sv
rtl/cpd_parser.sv
rtl/cpd_out_buf.sv
rtl/crc8_packet_deframer.sv
tb/crc8_packet_deframer_tb.sv
